>>> hdl/tsu_pkg.sv
// ----------------------------------------------------------------------------
// tsu_pkg
// Types, constants and encoding functions for the text string to UTF-8
// converter.
// ----------------------------------------------------------------------------
package tsu_pkg;

  typedef enum logic [1:0] {
    PH_FIRST   = 2'd0,
    PH_HELD_FE = 2'd1,
    PH_BODY    = 2'd2
  } tsu_phase_t;

  localparam logic [7:0]  BOM_HI         = 8'hFE;
  localparam logic [7:0]  BOM_LO         = 8'hFF;
  localparam logic [7:0]  CONT_TAG       = 8'h80;
  localparam logic [7:0]  LEAD2_TAG      = 8'hC0;
  localparam logic [7:0]  LEAD3_TAG      = 8'hE0;
  localparam logic [7:0]  CONT_MASK      = 8'h3F;
  localparam logic [15:0] ASCII_LIMIT    = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

  // one encoded character: up to three bytes, unused bytes zero
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n;
  } tsu_enc_t;

  // all bytes caused by one input item; count 0 is an empty end marker
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            done;
  } tsu_group_t;

  function automatic tsu_enc_t enc_latin1(logic [7:0] c);
    tsu_enc_t e;
    e = '0;
    if ({8'h00, c} < ASCII_LIMIT) begin
      e.bytes[0] = c;
      e.n        = 2'd1;
    end else begin
      e.bytes[0] = LEAD2_TAG | {6'b0, c[7:6]};
      e.bytes[1] = CONT_TAG | (c & CONT_MASK);
      e.n        = 2'd2;
    end
    return e;
  endfunction

  // surrogates pass through unpaired, one unit at a time
  function automatic tsu_enc_t enc_unit(logic [15:0] u);
    tsu_enc_t e;
    e = '0;
    if (u < ASCII_LIMIT) begin
      e.bytes[0] = u[7:0];
      e.n        = 2'd1;
    end else if (u < TWO_BYTE_LIMIT) begin
      e.bytes[0] = LEAD2_TAG | {3'b0, u[10:6]};
      e.bytes[1] = CONT_TAG | (u[7:0] & CONT_MASK);
      e.n        = 2'd2;
    end else begin
      e.bytes[0] = LEAD3_TAG | {4'b0, u[15:12]};
      e.bytes[1] = CONT_TAG | {2'b0, u[11:6]};
      e.bytes[2] = CONT_TAG | (u[7:0] & CONT_MASK);
      e.n        = 2'd3;
    end
    return e;
  endfunction

endpackage

>>> hdl/tsu_in_if.sv
// ----------------------------------------------------------------------------
// tsu_in_if
// Input channel: raw string bytes with an end-of-string flag.
// ----------------------------------------------------------------------------
interface tsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

>>> hdl/tsu_out_if.sv
// ----------------------------------------------------------------------------
// tsu_out_if
// Result channel: UTF-8 bytes with end markers.
// ----------------------------------------------------------------------------
interface tsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       text_done;

  modport source (output valid, output out_byte, output byte_valid,
                  output run_last, output text_done, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input run_last, input text_done, output ready);
endinterface

>>> hdl/tsu_front.sv
// ----------------------------------------------------------------------------
// tsu_front
// Accepts string bytes, tracks BOM detection and unit pairing, and builds
// the group of UTF-8 bytes that each item causes.
// ----------------------------------------------------------------------------
module tsu_front
  import tsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  tsu_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       q_push,
  output tsu_group_t q_data
);

  tsu_phase_t phase_r, phase_nxt;
  logic       wide_r, wide_nxt;
  logic [7:0] held_r, held_nxt;
  logic       held_v_r, held_v_nxt;

  logic       accept;
  logic       is_end;
  logic [7:0] b;
  tsu_enc_t   enc_a, enc_h, enc_u;
  tsu_group_t grp;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign is_end      = in_ch.string_end;

  assign enc_a = enc_latin1(b);
  assign enc_h = enc_latin1(held_r);
  assign enc_u = enc_unit({held_r, b});

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    wide_nxt   = wide_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    if (accept) begin
      unique case (phase_r)
        PH_FIRST: begin
          if (!is_end && b == BOM_HI) begin
            held_nxt   = b;
            held_v_nxt = 1'b1;
            phase_nxt  = PH_HELD_FE;
          end else begin
            wide_nxt  = 1'b0;
            phase_nxt = PH_BODY;
          end
        end
        PH_HELD_FE: begin
          wide_nxt   = (b == BOM_LO);
          held_nxt   = '0;
          held_v_nxt = 1'b0;
          phase_nxt  = PH_BODY;
        end
        default: begin
          if (wide_r) begin
            if (held_v_r) begin
              held_nxt   = '0;
              held_v_nxt = 1'b0;
            end else begin
              held_nxt   = b;
              held_v_nxt = 1'b1;
            end
          end
        end
      endcase
      if (is_end) begin
        phase_nxt  = PH_FIRST;
        wide_nxt   = 1'b0;
        held_nxt   = '0;
        held_v_nxt = 1'b0;
      end
    end
  end

  // group of result bytes for the current item
  always_comb begin
    grp = '0;
    unique case (phase_r)
      PH_FIRST: begin
        if (!(!is_end && b == BOM_HI)) begin
          grp.bytes[2:0] = enc_a.bytes;
          grp.count      = {1'b0, enc_a.n};
        end
      end
      PH_HELD_FE: begin
        // held byte is always FE here, so it encodes to two bytes
        if (b != BOM_LO) begin
          grp.bytes[1:0] = enc_h.bytes[1:0];
          grp.bytes[3:2] = enc_a.bytes[1:0];
          grp.count      = {1'b0, enc_h.n} + {1'b0, enc_a.n};
        end
      end
      default: begin
        if (wide_r) begin
          if (held_v_r) begin
            grp.bytes[2:0] = enc_u.bytes;
            grp.count      = {1'b0, enc_u.n};
          end
        end else begin
          grp.bytes[2:0] = enc_a.bytes;
          grp.count      = {1'b0, enc_a.n};
        end
      end
    endcase
    grp.done = is_end;
  end

  assign q_push = accept && (grp.count != 3'd0 || is_end);
  assign q_data = grp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      wide_r   <= 1'b0;
      held_r   <= '0;
      held_v_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      wide_r   <= wide_nxt;
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
    end
  end

endmodule

>>> hdl/tsu_queue.sv
// ----------------------------------------------------------------------------
// tsu_queue
// Short register queue of byte groups between front and back.
// ----------------------------------------------------------------------------
module tsu_queue
  import tsu_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tsu_group_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output tsu_group_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tsu_group_t          mem_r [DEPTH];
  logic [PW-1:0]       wr_r, wr_nxt;
  logic [PW-1:0]       rd_r, rd_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < CW'(DEPTH) || pop))
    else $error("tsu_queue: push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("tsu_queue: pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("tsu_queue: fill count lost a push");

endmodule

>>> hdl/tsu_back.sv
// ----------------------------------------------------------------------------
// tsu_back
// Serializes queued byte groups onto the result channel, one byte a cycle
// while the channel is ready, through an output register.
// ----------------------------------------------------------------------------
module tsu_back
  import tsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  tsu_group_t head,
  output logic       pop,
  tsu_out_if.source  out_ch
);

  logic [1:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] byte_r;
  logic       bv_r, last_r, done_r;

  logic       load;
  logic [1:0] last_idx;
  logic       at_last;

  assign last_idx = (head.count == 3'd0) ? 2'd0 : 2'(head.count - 3'd1);
  assign at_last  = (idx_r == last_idx);
  assign load     = head_valid && (!ov_r || out_ch.ready);
  assign pop      = load && at_last;

  always_comb begin
    idx_nxt = idx_r;
    ov_nxt  = ov_r;
    if (load) begin
      idx_nxt = at_last ? 2'd0 : idx_r + 2'd1;
      ov_nxt  = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= (head.count == 3'd0) ? 8'h00 : head.bytes[idx_r];
      bv_r   <= (head.count != 3'd0);
      last_r <= at_last;
      done_r <= at_last && head.done;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.out_byte   = byte_r;
  assign out_ch.byte_valid = bv_r;
  assign out_ch.run_last   = last_r;
  assign out_ch.text_done  = done_r;

  a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !bv_r) |-> (last_r && done_r))
    else $error("tsu_back: empty marker not flagged as end");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx_r <= last_idx)
    else $error("tsu_back: byte index past end of group");

endmodule

>>> hdl/text_string_to_utf8.sv
// ----------------------------------------------------------------------------
// text_string_to_utf8
// Converts a text string (UTF-16BE after an FE FF mark, else Latin-1),
// delivered one byte per item, into UTF-8 bytes.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                     handshake
//  in_ch    in   in_byte[7:0], string_end                    valid/ready
//  out_ch   out  out_byte[7:0], byte_valid, run_last,        valid/ready
//                text_done
//
//  Front takes one item a cycle while the group queue has room.
//  Back emits one byte a cycle while out_ch is ready; each item holds it for
//  the bytes it causes (none for a byte that is only held, one for an end
//  marker, up to 4), so the output register sets the sustained rate.
//  In to out passes through the group queue and the output register.
//  Synchronous active-low reset; no clearing pass. Either side may stall.
// ----------------------------------------------------------------------------
module text_string_to_utf8
  import tsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  tsu_in_if.sink    in_ch,
  tsu_out_if.source out_ch
);

  logic       q_full;
  logic       q_push;
  tsu_group_t q_data;
  logic       q_pop;
  logic       q_head_valid;
  tsu_group_t q_head;

  tsu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  tsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  tsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule
